// ===== src/sle_pkg.sv =====
// Package for the sequential list engine: sizes, request/response payloads,
// function and status codes, and the command broadcast to the entry cells.
// No dependencies.
package sle_pkg;

   // Number of list entries held in the cell chain
   localparam int DEPTH = 128;
   // Cell index width and length counter width (length runs 0..DEPTH)
   localparam int IDX_W = $clog2(DEPTH);
   localparam int LEN_W = $clog2(DEPTH + 1);
   // Common width for position/length compares, one spare bit for pos+1
   localparam int CMP_W = ((LEN_W > 8) ? LEN_W : 8) + 1;

   typedef enum logic [2:0] {
      FUNC_CLEAR  = 3'd0,
      FUNC_APPEND = 3'd1,
      FUNC_READ   = 3'd2,
      FUNC_NEIGH  = 3'd3,
      FUNC_SEARCH = 3'd4,
      FUNC_DELETE = 3'd5,
      FUNC_INSERT = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_NOKEY  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         func;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] value_out;
      logic signed [31:0] next_value;
      logic               has_before;
      logic               has_after;
      logic [6:0]         found_index;
      logic [7:0]         length_out;
   } rsp_type;

   // What every cell does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_ROTATE = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_DELETE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [IDX_W-1:0]  pos;
      logic [31:0]       value;
   } cell_cmd_type;

endpackage

// ===== src/sequential_list_engine.sv =====
// Top level of the sequential list engine: a ring of DEPTH entry cells and
// the sequencer that drives them. Depends on sle_pkg, sle_cell, sle_ctrl.
//
// Usage:
//   A request (req_data: func, position, value) is taken at a rising edge
//   with start high and busy low. Each request gives one response on
//   rsp_data, shown for exactly one cycle with rsp_valid high; the receiver
//   cannot stall it.
//   Clear, append, delete, insert, unused codes and requests rejected with
//   bad position or list full need no scan: the response shows the cycle
//   after acceptance and busy stays low, so one of these requests can be
//   taken every cycle. Insert and delete shift the cells at and after the
//   position in parallel. Read, neighbors and search rotate the whole ring
//   once, one cell a cycle, while the sequencer watches the head cell:
//   busy is high for the whole turn and the response shows in the cycle
//   busy falls.
//   Reset (synchronous, active high) empties the list and returns to idle;
//   entry contents are not cleared, and only positions below the length
//   are ever read.
module sequential_list_engine
   import sle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cell_cmd_type cmd;
   logic [31:0]  cell_data [DEPTH];

   // sequencer
   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .head_data (cell_data[0]),
      .cmd       (cmd)
   );

   // ring of entry cells, cell 0 is the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sle_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(i)),
         .left_data  (cell_data[(i + DEPTH - 1) % DEPTH]),
         .right_data (cell_data[(i + 1) % DEPTH]),
         .data_out   (cell_data[i])
      );
   end

endmodule

// ===== src/sle_cell.sv =====
// One entry cell of the list chain: holds one 32-bit entry and loads from
// its left or right neighbor, or the request value, as the command says.
// Depends on sle_pkg.
module sle_cell
   import sle_pkg::*;
(
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic [IDX_W-1:0] cell_index,
   input  logic [31:0]      left_data,
   input  logic [31:0]      right_data,
   output logic [31:0]      data_out
);

   logic [31:0] data_ff;
   logic [31:0] data_in;

   // Next entry value
   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
            data_in = data_ff;
         end
         CELL_ROTATE: begin
            data_in = right_data;
         end
         CELL_INSERT: begin
            // entries at and after the slot move right, slot takes the value
            if (cell_index > cmd.pos) begin
               data_in = left_data;
            end else if (cell_index == cmd.pos) begin
               data_in = cmd.value;
            end
         end
         CELL_DELETE: begin
            // entries from the slot on move left
            if (cell_index >= cmd.pos) begin
               data_in = right_data;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

// ===== src/sle_ctrl.sv =====
// Sequencer of the list engine: decodes requests, keeps the length, drives
// the cell command, and scans the rotating chain for read/neighbors/search.
// Depends on sle_pkg.
module sle_ctrl
   import sle_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type      req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  logic [31:0]  head_data,
   output cell_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] length_ff, length_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [2:0]       func_ff, func_in;
   logic [CMP_W-1:0] pos_ff, pos_in;
   logic [31:0]      key_ff, key_in;
   logic [31:0]      vout_ff, vout_in;
   logic [31:0]      vnext_ff, vnext_in;
   logic             hb_ff, hb_in;
   logic             ha_ff, ha_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] fidx_ff, fidx_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [CMP_W-1:0] pos_ext, len_ext, depth_ext, k_ext, len_in_ext, fidx_ext;
   logic             accept, resp_now;
   status_type       status_now;

   assign accept    = start && (state_ff == ST_IDLE);
   assign pos_ext   = CMP_W'(req_data.position);
   assign len_ext   = CMP_W'(length_ff);
   assign depth_ext = CMP_W'(DEPTH);
   assign k_ext     = CMP_W'(count_ff);

   always_comb begin
      state_in     = state_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      func_in      = func_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      vout_in      = vout_ff;
      vnext_in     = vnext_ff;
      hb_in        = hb_ff;
      ha_in        = ha_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      resp_now     = 1'b0;
      status_now   = STATUS_OK;
      cmd.op       = CELL_HOLD;
      cmd.pos      = pos_ext[IDX_W-1:0];
      cmd.value    = req_data.value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // clear scan results for this request
               func_in  = req_data.func;
               pos_in   = pos_ext;
               key_in   = req_data.value;
               vout_in  = '0;
               vnext_in = '0;
               hb_in    = 1'b0;
               ha_in    = 1'b0;
               found_in = 1'b0;
               fidx_in  = '0;
               count_in = '0;
               resp_now = 1'b1;
               unique case (req_data.func)
                  FUNC_CLEAR: begin
                     length_in = '0;
                  end
                  FUNC_APPEND: begin
                     if (len_ext >= depth_ext) begin
                        status_now = STATUS_FULL;
                     end else begin
                        cmd.op    = CELL_INSERT;
                        cmd.pos   = len_ext[IDX_W-1:0];
                        length_in = length_ff + LEN_W'(1);
                     end
                  end
                  FUNC_READ: begin
                     if (pos_ext >= len_ext) begin
                        status_now = STATUS_BADPOS;
                     end else begin
                        resp_now = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_NEIGH: begin
                     if (pos_ext >= len_ext) begin
                        status_now = STATUS_BADPOS;
                     end else begin
                        hb_in    = (pos_ext != '0);
                        ha_in    = ((pos_ext + CMP_W'(1)) < len_ext);
                        resp_now = 1'b0;
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_SEARCH: begin
                     resp_now = 1'b0;
                     state_in = ST_SCAN;
                  end
                  FUNC_DELETE: begin
                     if (pos_ext >= len_ext) begin
                        status_now = STATUS_BADPOS;
                     end else begin
                        cmd.op    = CELL_DELETE;
                        length_in = length_ff - LEN_W'(1);
                     end
                  end
                  FUNC_INSERT: begin
                     if (pos_ext > len_ext) begin
                        status_now = STATUS_BADPOS;
                     end else if (len_ext >= depth_ext) begin
                        status_now = STATUS_FULL;
                     end else begin
                        cmd.op    = CELL_INSERT;
                        length_in = length_ff + LEN_W'(1);
                     end
                  end
                  default: begin
                     // unused code: no change
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // chain rotates one place a cycle; head holds entry count_ff
            cmd.op   = CELL_ROTATE;
            count_in = count_ff + IDX_W'(1);
            unique case (func_ff)
               FUNC_READ: begin
                  if (k_ext == pos_ff) begin
                     vout_in = head_data;
                  end
               end
               FUNC_NEIGH: begin
                  if (hb_ff && (k_ext == (pos_ff - CMP_W'(1)))) begin
                     vout_in = head_data;
                  end
                  if (ha_ff && (k_ext == (pos_ff + CMP_W'(1)))) begin
                     vnext_in = head_data;
                  end
               end
               FUNC_SEARCH: begin
                  if (!found_ff && (k_ext < len_ext) && (head_data == key_ff)) begin
                     found_in = 1'b1;
                     fidx_in  = count_ff;
                  end
               end
               default: begin
               end
            endcase
            // a full turn puts every entry back in its own cell
            if (count_ff == IDX_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
               resp_now = 1'b1;
               if ((func_ff == FUNC_SEARCH) && !found_in) begin
                  status_now = STATUS_NOKEY;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // response assembly
      len_in_ext = CMP_W'(length_in);
      fidx_ext   = CMP_W'(fidx_in);
      if (resp_now) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = status_now;
         rsp_in.value_out   = vout_in;
         rsp_in.next_value  = vnext_in;
         rsp_in.has_before  = hb_in;
         rsp_in.has_after   = ha_in;
         rsp_in.found_index = fidx_ext[6:0];
         rsp_in.length_out  = len_in_ext[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff <= count_in;
      func_ff  <= func_in;
      pos_ff   <= pos_in;
      key_ff   <= key_in;
      vout_ff  <= vout_in;
      vnext_ff <= vnext_in;
      hb_ff    <= hb_in;
      ha_ff    <= ha_in;
      found_ff <= found_in;
      fidx_ff  <= fidx_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/sle_checker.sv =====
// Port-level checks for the sequential list engine, bound to the top level.
// Depends on sle_pkg and sequential_list_engine.
module sle_checker
   import sle_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every accepted request either answers next cycle or starts a scan
   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor scanning");

   // only read, neighbors and search start a scan
   a_scan_cause: assert property (@(posedge clock) disable iff (reset)
      ($rose(busy) && !$past(reset)) |->
         ($past(start) && ($past(req_data.func) == FUNC_READ ||
                           $past(req_data.func) == FUNC_NEIGH ||
                           $past(req_data.func) == FUNC_SEARCH)))
      else $error("scan started by wrong request");

   // end of a scan always shows its response
   a_scan_answers: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("scan ended without response");

   // clear answers next cycle with an empty list
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.func == FUNC_CLEAR)) |=>
         (rsp_valid && (rsp_data.length_out == 8'd0) &&
          (rsp_data.status == STATUS_OK)))
      else $error("clear response wrong");

   // length never exceeds the list depth
   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((DEPTH > 255) || (32'(rsp_data.length_out) <= 32'(DEPTH))))
      else $error("length beyond depth");

endmodule

bind sequential_list_engine sle_checker u_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Testbench for sequential_list_engine: directed and random list requests
// checked against a built-in list predictor. Depends on sle_pkg.
`timescale 1ns / 1ps

module tb_top
   import sle_pkg::*;
();

   // Code 7 is not used by the block; it must leave the list alone
   localparam logic [2:0] FUNC_UNUSED = 3'd7;
   localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Predictor copy of the list
   logic signed [31:0] list_mem [DEPTH];
   int unsigned        list_len = 0;

   rsp_type expected_rsp_q[$];
   int      error_count = 0;
   bit      sender_no_idle = 1'b0;

   sequential_list_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Apply one request to the predicted list and return the expected response
   function automatic rsp_type predict_list_op(req_type r);
      rsp_type     p;
      int unsigned pos;
      int unsigned m;
      p = '0;
      p.status = STATUS_OK;
      pos = r.position;
      case (r.func)
         FUNC_CLEAR: list_len = 0;
         FUNC_APPEND: begin
            if (list_len >= DEPTH) begin
               p.status = STATUS_FULL;
            end else begin
               list_mem[list_len] = r.value;
               list_len++;
            end
         end
         FUNC_READ: begin
            if (pos >= list_len) p.status = STATUS_BADPOS;
            else p.value_out = list_mem[pos];
         end
         FUNC_NEIGH: begin
            if (pos >= list_len) begin
               p.status = STATUS_BADPOS;
            end else begin
               if (pos > 0) begin
                  p.has_before = 1'b1;
                  p.value_out = list_mem[pos-1];
               end
               if (pos + 1 < list_len) begin
                  p.has_after = 1'b1;
                  p.next_value = list_mem[pos+1];
               end
            end
         end
         FUNC_SEARCH: begin
            p.status = STATUS_NOKEY;
            for (m = 0; m < list_len; m++) begin
               if (list_mem[m] == r.value) begin
                  p.status = STATUS_OK;
                  p.found_index = 7'(m);
                  break;
               end
            end
         end
         FUNC_DELETE: begin
            if (pos >= list_len) begin
               p.status = STATUS_BADPOS;
            end else begin
               for (m = pos; m + 1 < list_len; m++) list_mem[m] = list_mem[m+1];
               list_len--;
            end
         end
         FUNC_INSERT: begin
            if (pos > list_len) begin
               p.status = STATUS_BADPOS;
            end else if (list_len >= DEPTH) begin
               p.status = STATUS_FULL;
            end else begin
               for (m = list_len; m > pos; m--) list_mem[m] = list_mem[m-1];
               list_mem[pos] = r.value;
               list_len++;
            end
         end
         default: ;
      endcase
      p.length_out = 8'(list_len);
      return p;
   endfunction

   function automatic req_type make_req(logic [2:0] f, int pos, logic signed [31:0] v);
      req_type r;
      r.func = f;
      r.position = 7'(pos);
      r.value = v;
      return r;
   endfunction

   // Send one request: optional idle cycles, then hold start until taken
   task automatic send_request(input req_type r);
      while (!sender_no_idle && $urandom_range(99) < 38) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsp_q.push_back(predict_list_op(r));
   endtask

   // Hold off the sender until every pending response is back
   task automatic wait_for_responses();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_rsp_q.size() != 0);
   endtask

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Response checker: each response against the oldest expectation
   always @(posedge clock) begin
      rsp_type want_rsp;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            report_field("status", 32'(want_rsp.status), 32'(rsp_data.status));
            report_field("value_out", want_rsp.value_out, rsp_data.value_out);
            report_field("next_value", want_rsp.next_value, rsp_data.next_value);
            report_field("has_before", 32'(want_rsp.has_before), 32'(rsp_data.has_before));
            report_field("has_after", 32'(want_rsp.has_after), 32'(rsp_data.has_after));
            report_field("found_index", 32'(want_rsp.found_index),
                         32'(rsp_data.found_index));
            report_field("length_out", 32'(want_rsp.length_out), 32'(rsp_data.length_out));
         end
      end
   end

   // Read, neighbors, delete, search, insert and clear against an empty list
   task automatic test_empty_list();
      send_request(make_req(FUNC_READ, 0, 0));
      send_request(make_req(FUNC_NEIGH, 127, 0));
      send_request(make_req(FUNC_DELETE, 0, 0));
      send_request(make_req(FUNC_SEARCH, 0, MOST_NEG));
      send_request(make_req(FUNC_INSERT, 1, 5));
      send_request(make_req(FUNC_CLEAR, 0, 0));
   endtask

   // Short lists: single-entry neighbors, end insert, duplicates, extremes
   task automatic test_small_list();
      send_request(make_req(FUNC_INSERT, 0, MOST_NEG));
      send_request(make_req(FUNC_NEIGH, 0, 0));
      send_request(make_req(FUNC_APPEND, 0, MOST_POS));
      send_request(make_req(FUNC_APPEND, 0, 0));
      send_request(make_req(FUNC_INSERT, 3, -1));
      send_request(make_req(FUNC_INSERT, 5, 9));
      send_request(make_req(FUNC_APPEND, 0, 0));
      send_request(make_req(FUNC_READ, 1, 0));
      send_request(make_req(FUNC_NEIGH, 2, 0));
      send_request(make_req(FUNC_NEIGH, 4, 0));
      send_request(make_req(FUNC_SEARCH, 0, 0));
      send_request(make_req(FUNC_SEARCH, 0, MOST_NEG));
      send_request(make_req(FUNC_SEARCH, 0, 12345));
      send_request(make_req(FUNC_UNUSED, 127, MOST_POS));
      send_request(make_req(FUNC_DELETE, 0, 0));
      send_request(make_req(FUNC_DELETE, 3, 0));
      send_request(make_req(FUNC_READ, 127, 0));
      send_request(make_req(FUNC_CLEAR, 0, 0));
      send_request(make_req(FUNC_READ, 0, 0));
   endtask

   // Fill the list, then hit the full status and the top position
   task automatic test_full_list();
      int n;
      send_request(make_req(FUNC_CLEAR, 0, 0));
      for (n = 0; n < DEPTH; n++) send_request(make_req(FUNC_APPEND, 0, $urandom()));
      send_request(make_req(FUNC_APPEND, 0, 1));
      send_request(make_req(FUNC_INSERT, 0, 2));
      send_request(make_req(FUNC_INSERT, 127, 3));
      send_request(make_req(FUNC_READ, 127, 0));
      send_request(make_req(FUNC_NEIGH, 127, 0));
      send_request(make_req(FUNC_SEARCH, 0, list_mem[DEPTH-1]));
      send_request(make_req(FUNC_DELETE, 127, 0));
      send_request(make_req(FUNC_INSERT, 127, MOST_POS));
      send_request(make_req(FUNC_DELETE, 0, 0));
      send_request(make_req(FUNC_NEIGH, 0, 0));
   endtask

   // Random request; grow_pct steers how often the list gets longer
   function automatic req_type make_random_request(int grow_pct);
      req_type     r;
      int unsigned roll;
      int unsigned top;
      r.value = $urandom();
      r.position = 7'($urandom_range(127));
      roll = $urandom_range(99);
      if (roll < 2) r.func = FUNC_CLEAR;
      else if (roll < 3) r.func = FUNC_UNUSED;
      else if (roll < 3 + grow_pct) r.func = $urandom_range(1) ? FUNC_APPEND : FUNC_INSERT;
      else begin
         case ($urandom_range(3))
            0: r.func = FUNC_READ;
            1: r.func = FUNC_NEIGH;
            2: r.func = FUNC_SEARCH;
            default: r.func = FUNC_DELETE;
         endcase
      end
      // Mostly legal positions, sometimes past the end
      if ($urandom_range(99) < 85) begin
         top = (list_len > 127) ? 127 : list_len;
         r.position = 7'($urandom_range(top));
      end
      // Small values give duplicates; search keys mostly hit existing entries
      if ($urandom_range(99) < 30) r.value = $signed($urandom_range(8)) - 4;
      if (r.func == FUNC_SEARCH && list_len > 0 && $urandom_range(99) < 60)
         r.value = list_mem[$urandom_range(list_len - 1)];
      return r;
   endfunction

   task automatic test_random_mix(int count, int grow_pct);
      int n;
      for (n = 0; n < count; n++) send_request(make_random_request(grow_pct));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_small_list();
      wait_for_responses();
      test_full_list();
      wait_for_responses();

      test_random_mix(130, 20);
      wait_for_responses();
      // Long stretch with start held whenever possible, list driven to full
      sender_no_idle = 1'b1;
      test_random_mix(200, 60);
      sender_no_idle = 1'b0;
      test_random_mix(100, 5);
      wait_for_responses();
      repeat (DEPTH + 8) @(posedge clock);

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #6_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
